/* rtl/sdtw_pkg.sv */
// ----------------------------------------------------------------------------
// sdtw_pkg
// Types and constants shared by the short-descriptor table walker modules.
// ----------------------------------------------------------------------------
package sdtw_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SPLIT_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT     = 2'd2;

    // input item command
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_READ_DATA = 1'b1;

    // descriptor type codes
    localparam logic [1:0] L1_PAGE_TABLE = 2'd1;
    localparam logic [1:0] L1_SECTION    = 2'd2;
    localparam logic [1:0] L2_LARGE      = 2'd1;
    localparam int unsigned SUPER_BIT    = 18;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L2   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_IGNORED = 2'd2
    } t_kind;

    localparam logic [1:0] SIZE_SMALL   = 2'd0;
    localparam logic [1:0] SIZE_LARGE   = 2'd1;
    localparam logic [1:0] SIZE_SECTION = 2'd2;
    localparam logic [1:0] SIZE_SUPER   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_high;
        logic [ADDR_W-1:0]  base_low;
        logic [SPLIT_W-1:0] split;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic              fault;
        logic [1:0]        size;
    } t_result;

endpackage

/* rtl/sdtw_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sdtw_cfg_regs
// Translation table base and split registers, written over the config port.
// ----------------------------------------------------------------------------
module sdtw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [sdtw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdtw_pkg::ADDR_W-1:0]    i_cfg_data,
    output sdtw_pkg::t_cfg                 o_cfg
);
    import sdtw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_HIGH: r_cfg.base_high <= i_cfg_data;
                CFG_BASE_LOW:  r_cfg.base_low  <= i_cfg_data;
                CFG_SPLIT:     r_cfg.split     <= i_cfg_data[SPLIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/sdtw_walk.sv */
// ----------------------------------------------------------------------------
// sdtw_walk
// Walk state and the single-step logic that turns one item into one result.
// ----------------------------------------------------------------------------
module sdtw_walk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_cmd,
    input  logic [sdtw_pkg::ADDR_W-1:0] i_va,
    input  logic [sdtw_pkg::ADDR_W-1:0] i_data,
    input  sdtw_pkg::t_cfg              i_cfg,
    output sdtw_pkg::t_result           o_result
);
    import sdtw_pkg::*;

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_pending, n_pending;
    logic              r_use_low, n_use_low;

    logic              busy;
    logic [3:0]        low_shift;
    logic [ADDR_W-1:0] base_sel;
    logic              l1_low;
    logic [ADDR_W-1:0] l1_va;
    logic [ADDR_W-1:0] l1_addr;
    logic [ADDR_W-1:0] l2_addr;
    logic              l2_fault;

    assign busy = (r_phase == PH_L1) || (r_phase == PH_L2);

    // level-1 address, fresh request or retry under the low table
    assign l1_low    = (i_cmd == CMD_TRANSLATE) ? 1'b0 : 1'b1;
    assign l1_va     = (i_cmd == CMD_TRANSLATE) ? i_va : r_pending;
    assign low_shift = 4'd14 - {1'b0, i_cfg.split};
    assign base_sel  = l1_low ? (i_cfg.base_low & ({ADDR_W{1'b1}} << low_shift))
                              : {i_cfg.base_high[ADDR_W-1:14], 14'd0};
    assign l1_addr   = base_sel + {18'd0, l1_va[31:20], 2'b00};
    assign l2_addr   = {i_data[31:10], 10'd0} + {22'd0, r_pending[19:12], 2'b00};

    assign l2_fault  = !i_data[1] && (i_data[1:0] != L2_LARGE);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_use_low = r_use_low;
        if (i_cmd == CMD_TRANSLATE) begin
            if (!busy) begin
                n_pending = i_va;
                n_use_low = 1'b0;
                n_phase   = PH_L1;
            end
        end else begin
            case (r_phase)
                PH_L1: begin
                    if (i_data[1:0] == L1_PAGE_TABLE) begin
                        n_phase = PH_L2;
                    end else if (i_data[1:0] == L1_SECTION) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase   = r_use_low ? PH_IDLE : PH_L1;
                        n_use_low = 1'b1;
                    end
                end
                PH_L2: begin
                    if (l2_fault) begin
                        n_phase   = r_use_low ? PH_IDLE : PH_L1;
                        n_use_low = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_result      = '0;
        o_result.kind = KIND_IGNORED;
        if (i_cmd == CMD_TRANSLATE) begin
            if (!busy) begin
                o_result.kind    = KIND_READ;
                o_result.address = l1_addr;
            end
        end else begin
            case (r_phase)
                PH_L1: begin
                    if (i_data[1:0] == L1_PAGE_TABLE) begin
                        o_result.kind    = KIND_READ;
                        o_result.address = l2_addr;
                    end else if (i_data[1:0] == L1_SECTION) begin
                        o_result.kind = KIND_DONE;
                        if (i_data[SUPER_BIT]) begin
                            o_result.address = {i_data[31:24], r_pending[23:0]};
                            o_result.size    = SIZE_SUPER;
                        end else begin
                            o_result.address = {i_data[31:20], r_pending[19:0]};
                            o_result.size    = SIZE_SECTION;
                        end
                    end else if (!r_use_low) begin
                        o_result.kind    = KIND_READ;
                        o_result.address = l1_addr;
                    end else begin
                        o_result.kind  = KIND_DONE;
                        o_result.fault = 1'b1;
                    end
                end
                PH_L2: begin
                    if (i_data[1]) begin
                        o_result.kind    = KIND_DONE;
                        o_result.address = {i_data[31:12], r_pending[11:0]};
                        o_result.size    = SIZE_SMALL;
                    end else if (!l2_fault) begin
                        o_result.kind    = KIND_DONE;
                        o_result.address = {i_data[31:16], r_pending[15:0]};
                        o_result.size    = SIZE_LARGE;
                    end else if (!r_use_low) begin
                        o_result.kind    = KIND_READ;
                        o_result.address = l1_addr;
                    end else begin
                        o_result.kind  = KIND_DONE;
                        o_result.fault = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= '0;
            r_use_low <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_use_low <= n_use_low;
        end
    end

endmodule

/* rtl/sdtw_out_buf.sv */
// ----------------------------------------------------------------------------
// sdtw_out_buf
// Result register with a skid entry, so the input side keeps moving
// while a result waits on the output side.
// ----------------------------------------------------------------------------
module sdtw_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sdtw_pkg::t_result   i_result,
    output logic                o_valid,
    input  logic                i_ready,
    output sdtw_pkg::t_result   o_result
);
    import sdtw_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take;
    logic    drain;

    assign o_ready = !r_skid_valid;
    assign take    = i_valid && !r_skid_valid;
    assign drain   = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || drain) begin
            r_out_valid  <= r_skid_valid || take;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || drain) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (take && r_out_valid && !drain) begin
            r_skid <= i_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/short_descriptor_table_walker.sv */
// ----------------------------------------------------------------------------
// short_descriptor_table_walker
// Two-level short-descriptor page table walker: each item (a translate
// request or returned descriptor data) gives one result item, either a
// descriptor read request or the finished translation.
//
//   channel   direction  signals                          handshake
//   s         in         tdata, tuser (cmd)               tvalid & tready
//   m         out        tdata, tuser (kind)              tvalid & tready
//   cfg       in         index, data                      valid & ready
//
// one item per cycle while s ready is high; each result is registered before it appears on m
// walk state advances in the cycle an item is accepted
// a result register plus one skid entry part input from output
// s ready drops only when both are full; cfg is always ready
// synchronous active-low reset clears walk state and config registers
// ----------------------------------------------------------------------------
module short_descriptor_table_walker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [sdtw_pkg::S_TDATA_W-1:0] i_s_tdata,  // virtual_address, read_data
    input  logic                           i_s_tuser,  // cmd
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [sdtw_pkg::M_TDATA_W-1:0] o_m_tdata,  // address, fault, page_size_code
    output logic [1:0]                     o_m_tuser,  // kind
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sdtw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdtw_pkg::ADDR_W-1:0]    i_cfg_data
);
    import sdtw_pkg::*;

    t_cfg    cfg;
    t_result step_result;
    t_result out_result;
    logic    s_ready;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && s_ready;
    assign o_s_tready  = s_ready;

    sdtw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdtw_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_s_tuser),
        .i_va     (i_s_tdata[31:0]),
        .i_data   (i_s_tdata[63:32]),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    sdtw_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (s_ready),
        .i_result (step_result),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {5'd0, out_result.size, out_result.fault, out_result.address};
    assign o_m_tuser = out_result.kind;

endmodule
